/* src/sre_pkg.sv */
// shared types, constants and the character classifier for the expression recognizer
// used by the stack ram, the controller and the top level
// no dependencies
package sre_pkg;

  // symbol stack geometry
  localparam int unsigned STACK_DEPTH = 128;
  localparam int unsigned AW          = $clog2(STACK_DEPTH);
  localparam int unsigned CW          = $clog2(STACK_DEPTH + 1);

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] count_t;

  // ascii codes of the grammar characters
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  // symbol classes held on the stack
  typedef enum logic [2:0] {
    CL_OTHER = 3'd0,
    CL_S     = 3'd1,
    CL_I     = 3'd2,
    CL_PLUS  = 3'd3,
    CL_MINUS = 3'd4,
    CL_OPEN  = 3'd5,
    CL_CLOSE = 3'd6
  } cls_e;

  // stack ram access: one write, two reads per cycle
  typedef struct packed {
    logic  we;
    addr_t waddr;
    cls_e  wdata;
    addr_t raddr0;
    addr_t raddr1;
  } ram_req_t;

  typedef struct packed {
    cls_e rdata0;
    cls_e rdata1;
  } ram_rsp_t;

  // one result item
  typedef struct packed {
    logic [7:0] depth;
    logic [1:0] reductions;
    logic       done_res;
    logic       accepted;
    logic       overflow;
  } res_t;

  function automatic cls_e classify(input logic [7:0] ch);
    cls_e cls;
    case (ch)
      CH_S:     cls = CL_S;
      CH_I:     cls = CL_I;
      CH_PLUS:  cls = CL_PLUS;
      CH_MINUS: cls = CL_MINUS;
      CH_OPEN:  cls = CL_OPEN;
      CH_CLOSE: cls = CL_CLOSE;
      default:  cls = CL_OTHER;
    endcase
    return cls;
  endfunction

endpackage

/* src/sre_if.sv */
// valid/ready channel interfaces for the expression recognizer
// sre_in_if carries characters, sre_out_if carries result items; no dependencies
interface sre_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface sre_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] depth;
  logic [1:0] reductions;
  logic       done_res;
  logic       accepted;
  logic       overflow;

  modport source (output valid, output depth, output reductions, output done_res,
                  output accepted, output overflow, input ready);
  modport sink   (input valid, input depth, input reductions, input done_res,
                  input accepted, input overflow, output ready);
endinterface

/* src/shift_reduce_expression_recognizer_top.sv */
// Expression recognizer for the grammar S -> S+S | S-S | (S) | i.
//
// in_i takes one ascii character per item with a last flag; out_o gives one
// result item per character: stack depth, reductions done for it, and on the
// last character the verdict (accepted) and the sticky overflow flag.
// Both channels are valid/ready; an item moves when valid and ready are high.
//
// Each character passes through the accept and push step, one reduction check
// per reduction plus a final one (at most two reductions, so at most three checks)
// and a fetch step after each three-symbol reduction to refill the two entries
// below the new top from the stack ram. Its result is loaded into the output
// register once no rule applies and the register is free; one item is in flight at a time.
// A finished result sits in the output register; the next character is
// accepted while it waits. If the receiver stalls, the following result is
// held in the sequencer until the output register frees up.
// Reset clears the stack count, the overflow flag and both channels; the stack
// ram needs no clearing since only entries below the count are ever used.
// Depends on sre_pkg, sre_if, sre_stack_ram and sre_ctrl.
module shift_reduce_expression_recognizer_top (
  input  logic   clk_i,
  input  logic   rst_ni,
  sre_in_if.sink    in_i,
  sre_out_if.source out_o
);

  sre_pkg::ram_req_t ram_req;
  sre_pkg::ram_rsp_t ram_rsp;
  sre_pkg::res_t     res;
  logic              res_load;
  logic              out_free;
  logic              out_valid_q;
  sre_pkg::res_t     out_res_q;

  sre_stack_ram u_ram (
    .clk_i (clk_i),
    .req_i (ram_req),
    .rsp_o (ram_rsp)
  );

  sre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .ram_req_o  (ram_req),
    .ram_rsp_i  (ram_rsp),
    .out_free_i (out_free),
    .res_load_o (res_load),
    .res_o      (res)
  );

  // output register
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.depth      = out_res_q.depth;
  assign out_o.reductions = out_res_q.reductions;
  assign out_o.done_res   = out_res_q.done_res;
  assign out_o.accepted   = out_res_q.accepted;
  assign out_o.overflow   = out_res_q.overflow;

endmodule

/* src/sre_stack_ram.sv */
// symbol stack storage: one write port, two registered read ports
// depends on sre_pkg for geometry and the request/response structs
module sre_stack_ram (
  input  logic              clk_i,
  input  sre_pkg::ram_req_t req_i,
  output sre_pkg::ram_rsp_t rsp_o
);

  sre_pkg::cls_e mem_q [sre_pkg::STACK_DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // read ports, registered
  always_ff @(posedge clk_i) begin
    rsp_o.rdata0 <= mem_q[req_i.raddr0];
    rsp_o.rdata1 <= mem_q[req_i.raddr1];
  end

endmodule

/* src/sre_ctrl.sv */
// shift/reduce sequencer: pushes each class while there is room, reduces at the top, builds the result
// keeps the top three entries in registers and refills them from sre_stack_ram
// depends on sre_pkg and sre_in_if
module sre_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  sre_in_if.sink            in_i,
  output sre_pkg::ram_req_t ram_req_o,
  input  sre_pkg::ram_rsp_t ram_rsp_i,
  input  logic              out_free_i,
  output logic              res_load_o,
  output sre_pkg::res_t     res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_FETCH
  } state_e;

  state_e           state_q;
  sre_pkg::count_t  count_q;
  logic             ovf_q;
  logic             last_q;
  logic [1:0]       red_q;
  sre_pkg::cls_e    top_q [3];

  logic          in_acc;
  sre_pkg::cls_e in_cls;
  logic          has_room;
  logic          triple_red;
  logic          i_red;
  logic [1:0]    red_inc;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_cls     = sre_pkg::classify(in_i.symbol);
  assign has_room   = (count_q < sre_pkg::CW'(sre_pkg::STACK_DEPTH));
  assign red_inc    = (red_q == 2'd3) ? red_q : red_q + 2'd1;

  // reduction rules on the cached top of stack
  assign triple_red = (count_q >= sre_pkg::CW'(3)) && (
      (top_q[2] == sre_pkg::CL_S && top_q[1] == sre_pkg::CL_PLUS && top_q[0] == sre_pkg::CL_S) ||
      (top_q[2] == sre_pkg::CL_S && top_q[1] == sre_pkg::CL_MINUS && top_q[0] == sre_pkg::CL_S) ||
      (top_q[2] == sre_pkg::CL_OPEN && top_q[1] == sre_pkg::CL_S &&
       top_q[0] == sre_pkg::CL_CLOSE));
  assign i_red = (count_q >= sre_pkg::CW'(1)) && (top_q[0] == sre_pkg::CL_I);

  // stack ram requests
  always_comb begin
    ram_req_o.we     = 1'b0;
    ram_req_o.waddr  = count_q[sre_pkg::AW-1:0];
    ram_req_o.wdata  = in_cls;
    ram_req_o.raddr0 = sre_pkg::AW'(count_q - sre_pkg::CW'(4));
    ram_req_o.raddr1 = sre_pkg::AW'(count_q - sre_pkg::CW'(5));
    case (state_q)
      ST_IDLE: begin
        ram_req_o.we = in_acc && has_room;
      end
      ST_REDUCE: begin
        ram_req_o.wdata = sre_pkg::CL_S;
        if (triple_red) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = sre_pkg::AW'(count_q - sre_pkg::CW'(3));
        end else if (i_red) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = sre_pkg::AW'(count_q - sre_pkg::CW'(1));
        end
      end
      default: ;
    endcase
  end

  // result item, taken when no rule applies and the output register is free
  assign res_load_o       = (state_q == ST_REDUCE) && !triple_red && !i_red && out_free_i;
  assign res_o.depth      = 8'(count_q);
  assign res_o.reductions = red_q;
  assign res_o.done_res   = last_q;
  assign res_o.overflow   = ovf_q;
  assign res_o.accepted   = last_q && !ovf_q && (count_q == sre_pkg::CW'(1)) &&
                            (top_q[0] == sre_pkg::CL_S);

  // sequencer state, count, sticky flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
      last_q  <= 1'b0;
      red_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            last_q  <= in_i.last;
            red_q   <= '0;
            state_q <= ST_REDUCE;
            if (has_room) begin
              count_q <= count_q + sre_pkg::CW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
          end
        end
        ST_REDUCE: begin
          if (triple_red) begin
            count_q <= count_q - sre_pkg::CW'(2);
            red_q   <= red_inc;
            state_q <= ST_FETCH;
          end else if (i_red) begin
            red_q <= red_inc;
          end else if (out_free_i) begin
            if (last_q) begin
              count_q <= '0;
              ovf_q   <= 1'b0;
            end
            state_q <= ST_IDLE;
          end
        end
        ST_FETCH: begin
          state_q <= ST_REDUCE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // top-of-stack cache
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc && has_room) begin
          top_q[2] <= top_q[1];
          top_q[1] <= top_q[0];
          top_q[0] <= in_cls;
        end
      end
      ST_REDUCE: begin
        if (triple_red || i_red) begin
          top_q[0] <= sre_pkg::CL_S;
        end
      end
      ST_FETCH: begin
        top_q[1] <= ram_rsp_i.rdata0;
        top_q[2] <= ram_rsp_i.rdata1;
      end
      default: ;
    endcase
  end

  // the stack never grows past its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sre_pkg::CW'(sre_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  // an irreducible stack allows at most two reductions per item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_q != 2'd3)
    else $error("more than two reductions for one item");

  // a three-symbol reduction pops two entries and refills the cache
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REDUCE && triple_red) |=>
      (state_q == ST_FETCH && count_q == $past(count_q) - sre_pkg::CW'(2)))
    else $error("bad pop on three-symbol reduction");

  // an accepted verdict only on the last item of an unoverflowed string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load_o && res_o.accepted) |-> (last_q && !ovf_q && count_q == sre_pkg::CW'(1)))
    else $error("accept without single symbol");

endmodule
